// File: src/decision_tree_classify_unit_macros.svh
// Assertion macros shared by the decision tree classifier RTL.
`ifndef DECISION_TREE_CLASSIFY_UNIT_MACROS_SVH
`define DECISION_TREE_CLASSIFY_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define DTC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dtc: same-cycle check failed");
// Next-cycle implication, sampled on clk, off during reset.
`define DTC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dtc: next-cycle check failed");
`else
`define DTC_ASSERT_IMP(label, ante, cons)
`define DTC_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: src/dtc_pkg.sv
// Types, codes and sizes shared by the decision tree classifier modules.
`timescale 1ns / 1ps
package dtc_pkg;

	localparam int DTC_MAX_NODES    = 256;
	localparam int DTC_MAX_FEATURES = 64;
	localparam int NODE_SLOTS       = 256;
	localparam int FEATURE_SLOTS    = 64;
	localparam int NODE_IDX_W       = 8;
	localparam int FEAT_IDX_W       = 6;
	localparam int VALUE_W          = 32;

	localparam logic [1:0] OP_WRITE_NODE    = 2'd0;
	localparam logic [1:0] OP_WRITE_FEATURE = 2'd1;
	localparam logic [1:0] OP_CLASSIFY      = 2'd2;

	typedef struct packed {
		logic [1:0]                 opcode;
		logic [NODE_IDX_W-1:0]      node_index;
		logic                       is_terminal;
		logic [FEAT_IDX_W-1:0]      split_feature;
		logic signed [VALUE_W-1:0]  split_threshold;
		logic [NODE_IDX_W-1:0]      left_child;
		logic [NODE_IDX_W-1:0]      right_child;
		logic [7:0]                 leaf_class;
		logic [FEAT_IDX_W-1:0]      feature_index;
		logic signed [VALUE_W-1:0]  feature_value;
	} item_t;

	typedef struct packed {
		logic [7:0] predicted_class;
		logic [8:0] leaf_number;
		logic       walk_error;
	} result_t;

	// one tree node as stored in the node RAM
	typedef struct packed {
		logic                       is_terminal;
		logic [FEAT_IDX_W-1:0]      split_feature;
		logic signed [VALUE_W-1:0]  split_threshold;
		logic [NODE_IDX_W-1:0]      left_child;
		logic [NODE_IDX_W-1:0]      right_child;
		logic [7:0]                 leaf_class;
	} node_t;

	typedef struct packed {
		logic wr_node;
		logic wr_feat;
		logic start;
		logic feat_rd;
		logic step;
		logic load_leaf;
		logic load_err;
	} dtc_cmd_t;

	typedef struct packed {
		logic is_terminal;
		logic last_step;
	} dtc_status_t;

endpackage

// File: src/decision_tree_classify_unit.sv
// Decision tree classifier: stores a tree of up to 256 nodes and one sample,
// walks the tree from node 0 and returns the class of the leaf reached.
// Input channel item_valid/item_stall/item carries one operation per transfer:
// write a node, write a sample feature, or classify the current sample.
// Output channel result_valid/result_stall/result carries one result per
// classify: leaf class, one-based leaf number, and walk_error when the walk
// examines MAX_NODES nodes without meeting a leaf.
// Writes return nothing.
// A classify holds item_stall high for the whole walk: each node examined
// takes a node RAM read, then a feature RAM read and compare (ST_EVAL then
// ST_STEP), and a leaf is loaded into the result register from ST_EVAL;
// the next item is taken once the controller is back in ST_IDLE. The serial
// node/feature RAM reads mean a new item waits until the walk has ended.
// While the receiver stalls, the result register holds its item; writes are
// still taken, and a finished walk waits for the register to free up.
// Reset empties the result register and the walk state; node and feature
// storage keep their contents and are undefined until written.
`timescale 1ns / 1ps
`include "decision_tree_classify_unit_macros.svh"
module decision_tree_classify_unit #(
	parameter int MAX_NODES    = dtc_pkg::DTC_MAX_NODES,
	parameter int MAX_FEATURES = dtc_pkg::DTC_MAX_FEATURES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  dtc_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output dtc_pkg::result_t result
);

	import dtc_pkg::*;

	dtc_cmd_t    cmd;
	dtc_status_t status;

	dtc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (item.opcode),
		.status       (status),
		.cmd          (cmd),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

	dtc_datapath #(
		.MAX_NODES    (MAX_NODES),
		.MAX_FEATURES (MAX_FEATURES)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

	`DTC_ASSERT_NXT(a_classify_blocks_intake, item_valid && !item_stall && item.opcode == OP_CLASSIFY, item_stall)
	`DTC_ASSERT_IMP(a_load_only_when_free, cmd.load_leaf || cmd.load_err, !result_valid || !result_stall)
	`DTC_ASSERT_IMP(a_leaf_load_on_terminal, cmd.load_leaf, status.is_terminal && !cmd.load_err)
	`DTC_ASSERT_IMP(a_error_result_zeroed, result_valid && result.walk_error, result.leaf_number == 9'd0 && result.predicted_class == 8'd0)
	`DTC_ASSERT_IMP(a_leaf_number_nonzero, result_valid && !result.walk_error, result.leaf_number != 9'd0)

endmodule

// File: src/dtc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dtc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: src/dtc_datapath.sv
// Node and feature storage, walk registers, compare and result register.
`timescale 1ns / 1ps
module dtc_datapath #(
	parameter int MAX_NODES    = dtc_pkg::DTC_MAX_NODES,
	parameter int MAX_FEATURES = dtc_pkg::DTC_MAX_FEATURES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dtc_pkg::item_t       item,
	input  dtc_pkg::dtc_cmd_t    cmd,
	output dtc_pkg::dtc_status_t status,
	output dtc_pkg::result_t     result
);

	import dtc_pkg::*;

	localparam int FEAT_DEPTH = (MAX_FEATURES < FEATURE_SLOTS) ? MAX_FEATURES : FEATURE_SLOTS;
	localparam int FAW        = (FEAT_DEPTH > 1) ? $clog2(FEAT_DEPTH) : 1;
	localparam int SW         = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int NODE_W     = $bits(node_t);

	node_t                     wr_node_data;
	node_t                     node;
	logic [NODE_W-1:0]         node_raw;
	logic [VALUE_W-1:0]        feat_raw;
	logic signed [VALUE_W-1:0] feat_val;
	logic                      go_left;
	logic [NODE_IDX_W-1:0]     next_k;
	logic [NODE_IDX_W-1:0]     node_rd_addr;
	logic                      feat_wr_ok;
	logic                      feat_rd_ok;
	logic [NODE_IDX_W-1:0]     k_q;
	logic [SW-1:0]             steps_q;
	logic                      feat_ok_q;
	result_t                   result_q;

	assign wr_node_data = '{
		is_terminal:     item.is_terminal,
		split_feature:   item.split_feature,
		split_threshold: item.split_threshold,
		left_child:      item.left_child,
		right_child:     item.right_child,
		leaf_class:      item.leaf_class
	};

	assign node = node_t'(node_raw);

	// features at or beyond the configured count are dropped on write, read as zero
	assign feat_wr_ok = ({26'd0, item.feature_index} < 32'(MAX_FEATURES));
	assign feat_rd_ok = ({26'd0, node.split_feature} < 32'(MAX_FEATURES));

	assign feat_val = feat_ok_q ? $signed(feat_raw) : '0;
	assign go_left  = (feat_val <= node.split_threshold);
	assign next_k   = go_left ? node.left_child : node.right_child;

	assign node_rd_addr = cmd.start ? '0 : next_k;

	dtc_ram #(
		.WIDTH(NODE_W),
		.DEPTH(NODE_SLOTS)
	) u_node_ram (
		.clk     (clk),
		.wr_en   (cmd.wr_node),
		.wr_addr (item.node_index),
		.wr_data (NODE_W'(wr_node_data)),
		.rd_en   (cmd.start | cmd.step),
		.rd_addr (node_rd_addr),
		.rd_data (node_raw)
	);

	dtc_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(FEAT_DEPTH)
	) u_feat_ram (
		.clk     (clk),
		.wr_en   (cmd.wr_feat & feat_wr_ok),
		.wr_addr (item.feature_index[FAW-1:0]),
		.wr_data (VALUE_W'(item.feature_value)),
		.rd_en   (cmd.feat_rd),
		.rd_addr (node.split_feature[FAW-1:0]),
		.rd_data (feat_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= '0;
			steps_q   <= '0;
			feat_ok_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				k_q     <= '0;
				steps_q <= '0;
			end else if (cmd.step) begin
				k_q     <= next_k;
				steps_q <= steps_q + SW'(1);
			end
			if (cmd.feat_rd) begin
				feat_ok_q <= feat_rd_ok;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_leaf) begin
			result_q.predicted_class <= node.leaf_class;
			result_q.leaf_number     <= {1'b0, k_q} + 9'd1;
			result_q.walk_error      <= 1'b0;
		end else if (cmd.load_err) begin
			result_q.predicted_class <= '0;
			result_q.leaf_number     <= '0;
			result_q.walk_error      <= 1'b1;
		end
	end

	assign status.is_terminal = node.is_terminal;
	assign status.last_step   = (steps_q == SW'(MAX_NODES - 1));
	assign result             = result_q;

endmodule

// File: src/dtc_ctrl.sv
// Sequencer for item intake, the tree walk and the result register handshake.
`timescale 1ns / 1ps
module dtc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic [1:0]           opcode,
	input  dtc_pkg::dtc_status_t status,
	output dtc_pkg::dtc_cmd_t    cmd,
	output logic                 result_valid,
	input  logic                 result_stall
);

	import dtc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_STEP,
		ST_ERR
	} state_t;

	state_t state_q;
	logic   result_valid_q;
	logic   take;
	logic   out_free;

	assign item_stall = (state_q != ST_IDLE);
	assign take       = item_valid & ~item_stall;
	assign out_free   = ~result_valid_q | ~result_stall;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.wr_node = take & (opcode == OP_WRITE_NODE);
				cmd.wr_feat = take & (opcode == OP_WRITE_FEATURE);
				cmd.start   = take & (opcode == OP_CLASSIFY);
			end
			ST_EVAL: begin
				cmd.load_leaf = status.is_terminal & out_free;
				cmd.feat_rd   = ~status.is_terminal;
			end
			ST_STEP: begin
				cmd.step = 1'b1;
			end
			ST_ERR: begin
				cmd.load_err = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					// a leaf waits here until the result register frees up
					if (cmd.load_leaf) begin
						state_q <= ST_IDLE;
					end else if (!status.is_terminal) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					state_q <= status.last_step ? ST_ERR : ST_EVAL;
				end
				ST_ERR: begin
					if (cmd.load_err) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cmd.load_leaf || cmd.load_err) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;

endmodule
